>>> hdl/tse_pkg.sv
// Shared sizes, field layout and memory request structs for the topological sort engine.
// Used by tse_indeg, tse_ctrl, topological_sort_engine and tb; depends on nothing else.
package tse_pkg;

  localparam int MAX_NODES = 32;
  localparam int MAX_EDGES = 256;

  localparam int NODE_W  = 5;
  localparam int CNT_W   = 6;
  localparam int EDGE_AW = $clog2(MAX_EDGES);
  localparam int ETOT_W  = $clog2(MAX_EDGES + 1);
  localparam int DEG_W   = ETOT_W;
  localparam int EDGE_W  = 2 * NODE_W;
  localparam int QPTR_W  = $clog2(MAX_NODES + 1);
  localparam int QADDR_W = $clog2(MAX_NODES);

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  typedef struct packed {
    logic              we;
    logic [EDGE_AW-1:0] waddr;
    logic [EDGE_W-1:0]  wdata;
    logic [EDGE_AW-1:0] raddr;
  } edge_req_t;

  typedef struct packed {
    logic              clear;
    logic              we;
    logic [NODE_W-1:0] waddr;
    logic [DEG_W-1:0]  wdata;
    logic [NODE_W-1:0] raddr;
  } indeg_req_t;

  typedef struct packed {
    logic               we;
    logic [QADDR_W-1:0] waddr;
    logic [NODE_W-1:0]  wdata;
    logic [QADDR_W-1:0] raddr;
  } queue_req_t;

endpackage

>>> hdl/tse_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Standalone; instantiated for the edge store, the ready queue and the in-degree store.
module tse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/tse_indeg.sv
// In-degree store: a RAM plus one valid bit per node, so a single clear empties the whole store.
// Depends on tse_pkg and tse_ram.
module tse_indeg (
  input  logic                      clk,
  input  logic                      rst,
  input  tse_pkg::indeg_req_t       req,
  output logic [tse_pkg::DEG_W-1:0] rdata
);

  logic [tse_pkg::MAX_NODES-1:0] valid;
  logic                          rd_valid;
  logic [tse_pkg::DEG_W-1:0]     ram_q;

  tse_ram #(
    .WIDTH (tse_pkg::DEG_W),
    .DEPTH (tse_pkg::MAX_NODES)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .raddr (req.raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[req.raddr];
      if (req.clear) begin
        valid <= '0;
      end else if (req.we) begin
        valid[req.waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rd_valid ? ram_q : '0;

endmodule

>>> hdl/tse_ctrl.sv
// Sequencer for edge loading and Kahn ordering: drives the edge, queue and in-degree memories
// and holds the output word register. Depends on tse_pkg.
module tse_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [tse_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tuser,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [tse_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast,
  output tse_pkg::edge_req_t             edge_req,
  input  logic [tse_pkg::EDGE_W-1:0]     edge_rdata,
  output tse_pkg::indeg_req_t            indeg_req,
  input  logic [tse_pkg::DEG_W-1:0]      indeg_rdata,
  output tse_pkg::queue_req_t            queue_req,
  input  logic [tse_pkg::NODE_W-1:0]     queue_rdata
);

  typedef enum logic [3:0] {
    IDLE, CNT_RD, CNT_CHK, CNT_WR, SCAN_RD, SCAN_CHK,
    POP_RD, POP_EMIT, WALK_RD, WALK_CHK, WALK_WR, TERM
  } state_t;

  state_t                      state;
  logic [tse_pkg::ETOT_W-1:0]  total;
  logic                        overflow;
  logic [tse_pkg::CNT_W-1:0]   count;
  logic [tse_pkg::ETOT_W-1:0]  eidx;
  logic [tse_pkg::CNT_W-1:0]   nidx;
  logic [tse_pkg::QPTR_W-1:0]  head;
  logic [tse_pkg::QPTR_W-1:0]  tail;
  logic [tse_pkg::NODE_W-1:0]  cur_node;

  logic                        out_valid;
  logic [tse_pkg::NODE_W-1:0]  out_node;
  logic                        out_idx_valid;
  logic                        out_cyc;
  logic                        out_ovf;
  logic                        out_last;

  logic                        in_acc;
  logic                        out_free;
  logic                        out_load;
  logic [tse_pkg::CNT_W-1:0]   cnt_in;
  logic [tse_pkg::NODE_W-1:0]  edge_s;
  logic [tse_pkg::NODE_W-1:0]  edge_d;
  logic                        edge_in_range;
  logic                        edge_end;
  logic                        queue_room;
  logic                        queue_has;

  assign s_axis_tready = (state == IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign out_load      = ((state == POP_EMIT) || (state == TERM)) && out_free;
  assign cnt_in        = s_axis_tdata[5:0];

  assign edge_s        = edge_rdata[tse_pkg::EDGE_W-1:tse_pkg::NODE_W];
  assign edge_d        = edge_rdata[tse_pkg::NODE_W-1:0];
  assign edge_in_range = ({1'b0, edge_s} < count) && ({1'b0, edge_d} < count);
  assign edge_end      = (eidx == total);
  assign queue_room    = (tail < tse_pkg::QPTR_W'(tse_pkg::MAX_NODES));
  assign queue_has     = (head < tail) && (head < tse_pkg::QPTR_W'(tse_pkg::MAX_NODES));

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_ovf, out_cyc, out_node};
  assign m_axis_tuser  = out_idx_valid;
  assign m_axis_tlast  = out_last;

  always_comb begin
    edge_req.we    = in_acc && s_axis_tuser && (total < tse_pkg::ETOT_W'(tse_pkg::MAX_EDGES));
    edge_req.waddr = total[tse_pkg::EDGE_AW-1:0];
    edge_req.wdata = {s_axis_tdata[10:6], s_axis_tdata[15:11]};
    edge_req.raddr = eidx[tse_pkg::EDGE_AW-1:0];

    indeg_req.clear = (state == TERM) && out_free;
    indeg_req.we    = (state == CNT_WR) || ((state == WALK_WR) && (indeg_rdata != '0));
    indeg_req.waddr = edge_d;
    indeg_req.wdata = (state == CNT_WR) ? indeg_rdata + tse_pkg::DEG_W'(1)
                                        : indeg_rdata - tse_pkg::DEG_W'(1);
    indeg_req.raddr = ((state == SCAN_RD) || (state == SCAN_CHK)) ?
                      nidx[tse_pkg::NODE_W-1:0] : edge_d;

    queue_req.we    = queue_room &&
                      (((state == SCAN_CHK) && (indeg_rdata == '0)) ||
                       ((state == WALK_WR) && (indeg_rdata == tse_pkg::DEG_W'(1))));
    queue_req.waddr = tail[tse_pkg::QADDR_W-1:0];
    queue_req.wdata = (state == SCAN_CHK) ? nidx[tse_pkg::NODE_W-1:0] : edge_d;
    queue_req.raddr = head[tse_pkg::QADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      total     <= '0;
      overflow  <= 1'b0;
      count     <= '0;
      eidx      <= '0;
      nidx      <= '0;
      head      <= '0;
      tail      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready && !out_load) begin
        out_valid <= 1'b0;
      end
      if (queue_req.we) begin
        tail <= tail + tse_pkg::QPTR_W'(1);
      end
      unique case (state)
        IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser) begin
              if (edge_req.we) begin
                total <= total + tse_pkg::ETOT_W'(1);
              end else begin
                overflow <= 1'b1;
              end
            end
            if (s_axis_tlast) begin
              count <= (cnt_in > tse_pkg::CNT_W'(tse_pkg::MAX_NODES)) ?
                       tse_pkg::CNT_W'(tse_pkg::MAX_NODES) : cnt_in;
              eidx  <= '0;
              state <= CNT_RD;
            end
          end
        end
        CNT_RD: begin
          if (edge_end) begin
            nidx  <= '0;
            state <= SCAN_RD;
          end else begin
            state <= CNT_CHK;
          end
        end
        CNT_CHK: begin
          if (edge_in_range) begin
            state <= CNT_WR;
          end else begin
            eidx  <= eidx + tse_pkg::ETOT_W'(1);
            state <= CNT_RD;
          end
        end
        CNT_WR: begin
          eidx  <= eidx + tse_pkg::ETOT_W'(1);
          state <= CNT_RD;
        end
        SCAN_RD: begin
          state <= (nidx == count) ? POP_RD : SCAN_CHK;
        end
        SCAN_CHK: begin
          nidx  <= nidx + tse_pkg::CNT_W'(1);
          state <= SCAN_RD;
        end
        POP_RD: begin
          state <= queue_has ? POP_EMIT : TERM;
        end
        POP_EMIT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            out_node      <= queue_rdata;
            out_idx_valid <= 1'b1;
            out_cyc       <= 1'b0;
            out_ovf       <= overflow;
            out_last      <= 1'b0;
            cur_node      <= queue_rdata;
            head          <= head + tse_pkg::QPTR_W'(1);
            eidx          <= '0;
            state         <= WALK_RD;
          end
        end
        WALK_RD: begin
          state <= edge_end ? POP_RD : WALK_CHK;
        end
        WALK_CHK: begin
          if (edge_in_range && (edge_s == cur_node)) begin
            state <= WALK_WR;
          end else begin
            eidx  <= eidx + tse_pkg::ETOT_W'(1);
            state <= WALK_RD;
          end
        end
        WALK_WR: begin
          eidx  <= eidx + tse_pkg::ETOT_W'(1);
          state <= WALK_RD;
        end
        TERM: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            out_node      <= '0;
            out_idx_valid <= 1'b0;
            out_cyc       <= (tse_pkg::CNT_W'(head) != count);
            out_ovf       <= overflow;
            out_last      <= 1'b1;
            total         <= '0;
            overflow      <= 1'b0;
            head          <= '0;
            tail          <= '0;
            state         <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

>>> hdl/topological_sort_engine.sv
// Top level of the topological sort engine: edge store, ready queue, in-degree store, sequencer.
// Depends on tse_pkg, tse_ram, tse_indeg and tse_ctrl.
//
// Usage: each input word on s_axis carries at most one edge (tuser = has_edge) from
// edge_src to edge_dst; a word with tlast set ends the graph, takes node_count from
// it and starts the sort. Words without tlast produce nothing and are accepted back to back.
// The sort emits one m_axis word per ordered node (tuser high), then one terminator
// word with tlast high that reports cycle_detected and edge_overflow.
// While sorting, s_axis_tready stays low. For each sort the sequencer first counts the
// in-degrees over the stored edges and then scans the nodes for sources; each emitted
// node then takes a pop, an emit and a successor walk over the edge store, and the
// terminator word follows once the ready queue is empty. The edge store has a single
// read port and is walked in full for every popped node. Results sit in one output
// register; a stalled receiver holds the sequencer at its next emit until the word is
// taken, and a new word can be loaded in the cycle the old one leaves. Reset empties
// the graph and all in-degrees at once; edges beyond the edge store capacity are
// dropped and flagged in every result of that sort.
module topological_sort_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [tse_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // node_count[5:0], edge_src[10:6], edge_dst[15:11]
  input  logic                           s_axis_tuser,  // has_edge
  input  logic                           s_axis_tlast,  // last_item
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [tse_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // node_index[4:0], cycle_detected[5], edge_overflow[6], zero[7]
  output logic                           m_axis_tuser,  // index_valid
  output logic                           m_axis_tlast   // last_result
);

  tse_pkg::edge_req_t           edge_req;
  tse_pkg::indeg_req_t          indeg_req;
  tse_pkg::queue_req_t          queue_req;
  logic [tse_pkg::EDGE_W-1:0]   edge_rdata;
  logic [tse_pkg::DEG_W-1:0]    indeg_rdata;
  logic [tse_pkg::NODE_W-1:0]   queue_rdata;

  tse_ram #(
    .WIDTH (tse_pkg::EDGE_W),
    .DEPTH (tse_pkg::MAX_EDGES)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_req.we),
    .waddr (edge_req.waddr),
    .wdata (edge_req.wdata),
    .raddr (edge_req.raddr),
    .rdata (edge_rdata)
  );

  tse_ram #(
    .WIDTH (tse_pkg::NODE_W),
    .DEPTH (tse_pkg::MAX_NODES)
  ) u_queue_ram (
    .clk   (clk),
    .we    (queue_req.we),
    .waddr (queue_req.waddr),
    .wdata (queue_req.wdata),
    .raddr (queue_req.raddr),
    .rdata (queue_rdata)
  );

  tse_indeg u_indeg (
    .clk   (clk),
    .rst   (rst),
    .req   (indeg_req),
    .rdata (indeg_rdata)
  );

  tse_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .edge_req      (edge_req),
    .edge_rdata    (edge_rdata),
    .indeg_req     (indeg_req),
    .indeg_rdata   (indeg_rdata),
    .queue_req     (queue_req),
    .queue_rdata   (queue_rdata)
  );

  a_edge_wr_on_accept: assert property (@(posedge clk) disable iff (rst)
    edge_req.we |-> (s_axis_tvalid && s_axis_tready && s_axis_tuser))
    else $error("edge store written without an accepted edge word");

  a_queue_wr_in_sort: assert property (@(posedge clk) disable iff (rst)
    queue_req.we |-> !s_axis_tready)
    else $error("ready queue written outside the sort");

  a_indeg_wr_in_sort: assert property (@(posedge clk) disable iff (rst)
    (indeg_req.we || indeg_req.clear) |-> (!s_axis_tready && !(indeg_req.we && indeg_req.clear)))
    else $error("in-degree store update outside the sort or during clear");

  a_term_then_idle: assert property (@(posedge clk) disable iff (rst)
    indeg_req.clear |=> (s_axis_tready && m_axis_tvalid && m_axis_tlast && !m_axis_tuser))
    else $error("terminator word not presented when the sort ends");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for topological_sort_engine: directed and random graphs, Kahn order predicted here.
// Depends on tse_pkg and the topological_sort_engine RTL only.
module tb;

  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int RANDOM_WORDS = 30;
  localparam int EXP_DEPTH    = 256;

  localparam int GRAPH_DAG    = 0;
  localparam int GRAPH_CYCLIC = 1;
  localparam int GRAPH_NOISE  = 2;

  typedef struct packed {
    logic                       last;
    logic                       has_edge;
    logic [tse_pkg::NODE_W-1:0] dst;
    logic [tse_pkg::NODE_W-1:0] src;
    logic [tse_pkg::CNT_W-1:0]  count;
  } graph_word_t;

  typedef struct packed {
    logic                       last;
    logic                       ovf;
    logic                       cyc;
    logic                       valid;
    logic [tse_pkg::NODE_W-1:0] node;
  } order_word_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [tse_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                           s_axis_tuser = 1'b0;
  logic                           s_axis_tlast = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [tse_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tuser;
  logic                           m_axis_tlast;

  topological_sort_engine uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  logic [2*tse_pkg::NODE_W-1:0] graph_edges [tse_pkg::MAX_EDGES];
  int                           edge_total = 0;
  logic                         graph_overflow = 1'b0;
  order_word_t                  order_exp_mem [EXP_DEPTH];
  int                           exp_wr_cnt = 0;
  int                           exp_rd_cnt = 0;

  int errors = 0;
  int cycles = 0;
  int words_counted = 0;
  int burst_left = 0;
  bit sender_smooth = 1'b0;
  int hold_seq = 0;
  int hold_len = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  int rx_phase_left = 0;
  int rx_mode = 0;
  int rx_period = 2;
  int rx_tick = 0;
  int rx_hold_left = 0;
  int rx_hold_seen = 0;

  always @(posedge clk) begin
    if (hold_seq != rx_hold_seen) begin
      rx_hold_seen = hold_seq;
      rx_hold_left = hold_len;
    end
    if (rx_phase_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_phase_left = $urandom_range(20, 200);
      rx_period = $urandom_range(2, 5);
    end
    rx_phase_left--;
    rx_tick++;
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= ((rx_tick % rx_period) == 0);
        default: m_axis_tready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    order_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (exp_wr_cnt == exp_rd_cnt) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual tdata=%h tuser=%b tlast=%b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        want = order_exp_mem[exp_rd_cnt % EXP_DEPTH];
        exp_rd_cnt++;
        check_field("node_index", int'(want.node), int'(m_axis_tdata[4:0]));
        check_field("cycle_detected", int'(want.cyc), int'(m_axis_tdata[5]));
        check_field("edge_overflow", int'(want.ovf), int'(m_axis_tdata[6]));
        check_field("pad", 0, int'(m_axis_tdata[7]));
        check_field("index_valid", int'(want.valid), int'(m_axis_tuser));
        check_field("last_result", int'(want.last), int'(m_axis_tlast));
      end
    end
  end

  task automatic push_order(input int node, input bit valid, input bit cyc, input bit ovf,
                            input bit last);
    order_word_t r;
    r.node = node[tse_pkg::NODE_W-1:0];
    r.valid = valid;
    r.cyc = cyc;
    r.ovf = ovf;
    r.last = last;
    order_exp_mem[exp_wr_cnt % EXP_DEPTH] = r;
    exp_wr_cnt++;
  endtask

  task automatic predict_order(input logic [tse_pkg::CNT_W-1:0] count_field);
    int count, produced, head, tail, n, e, node;
    int indeg[tse_pkg::MAX_NODES];
    int ready_q[tse_pkg::MAX_NODES];
    logic [tse_pkg::NODE_W-1:0] s, d;
    count = (count_field > tse_pkg::MAX_NODES) ? tse_pkg::MAX_NODES : int'(count_field);
    produced = 0;
    for (n = 0; n < tse_pkg::MAX_NODES; n++) indeg[n] = 0;
    for (e = 0; e < edge_total; e++) begin
      {s, d} = graph_edges[e];
      if (s < count && d < count) indeg[d]++;
    end
    head = 0;
    tail = 0;
    for (n = 0; n < count; n++) begin
      if (indeg[n] == 0) begin
        ready_q[tail] = n;
        tail++;
      end
    end
    while (head < tail) begin
      node = ready_q[head];
      head++;
      push_order(node, 1'b1, 1'b0, graph_overflow, 1'b0);
      produced++;
      for (e = 0; e < edge_total; e++) begin
        {s, d} = graph_edges[e];
        if (s == node && s < count && d < count && indeg[d] > 0) begin
          indeg[d]--;
          if (indeg[d] == 0) begin
            ready_q[tail] = d;
            tail++;
          end
        end
      end
    end
    push_order(0, 1'b0, produced != count, graph_overflow, 1'b1);
    edge_total = 0;
    graph_overflow = 1'b0;
  endtask

  task automatic absorb_word(input graph_word_t w);
    if (w.has_edge) begin
      if (edge_total < tse_pkg::MAX_EDGES) begin
        graph_edges[edge_total] = {w.src, w.dst};
        edge_total++;
      end else begin
        graph_overflow = 1'b1;
      end
    end
    if (w.last) predict_order(w.count);
  endtask

  function automatic graph_word_t mk_word(input int count, input int src, input int dst,
                                          input bit has_edge, input bit last);
    graph_word_t w;
    w.count = count[tse_pkg::CNT_W-1:0];
    w.src = src[tse_pkg::NODE_W-1:0];
    w.dst = dst[tse_pkg::NODE_W-1:0];
    w.has_edge = has_edge;
    w.last = last;
    return w;
  endfunction

  task automatic send_word(input graph_word_t w);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {w.dst, w.src, w.count};
    s_axis_tuser <= w.has_edge;
    s_axis_tlast <= w.last;
    do @(posedge clk); while (!s_axis_tready);
    absorb_word(w);
    if (w.has_edge || w.last) words_counted++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      gap = sender_smooth ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (exp_wr_cnt != exp_rd_cnt);
  endtask

  task automatic send_graph(input int kind, input int n, input int m);
    int perm[tse_pkg::MAX_NODES];
    int i, j, t, a, b, first_s, first_d;
    int cnt, s, d;
    bit carry_last;
    for (i = 0; i < tse_pkg::MAX_NODES; i++) perm[i] = i;
    for (i = tse_pkg::MAX_NODES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    cnt = n;
    if (n == tse_pkg::MAX_NODES) cnt = $urandom_range(tse_pkg::MAX_NODES, 63);
    if (kind == GRAPH_NOISE) cnt = $urandom_range(0, 63);
    carry_last = (m > 0) && ($urandom_range(0, 2) == 0);
    first_s = 0;
    first_d = 0;
    for (i = 0; i < m; i++) begin
      if (kind == GRAPH_NOISE || n < 2) begin
        s = $urandom_range(0, 31);
        d = $urandom_range(0, 31);
      end else begin
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 2);
        if (b >= a) b++;
        if (a > b) begin
          t = a;
          a = b;
          b = t;
        end
        s = perm[a];
        d = perm[b];
      end
      if (i == 0) begin
        first_s = s;
        first_d = d;
      end
      if (kind == GRAPH_CYCLIC && i == m - 1) begin
        if (i == 0 || $urandom_range(0, 2) == 0) begin
          d = s;
        end else begin
          s = first_d;
          d = first_s;
        end
      end
      if ($urandom_range(0, 9) == 0)
        send_word(mk_word($urandom_range(0, 63), $urandom_range(0, 31), $urandom_range(0, 31),
                          1'b0, 1'b0));
      send_word(mk_word(cnt, s, d, 1'b1, carry_last && (i == m - 1)));
    end
    if (!carry_last)
      send_word(mk_word(cnt, $urandom_range(0, 31), $urandom_range(0, 31), 1'b0, 1'b1));
  endtask

  task automatic test_directed();
    sender_smooth = 1'b0;
    send_word(mk_word(0, 0, 0, 1'b0, 1'b1));
    send_word(mk_word(1, 0, 0, 1'b1, 1'b1));
    send_word(mk_word(0, 31, 0, 1'b1, 1'b0));
    send_word(mk_word(0, 31, 0, 1'b1, 1'b0));
    send_word(mk_word(0, 0, 5, 1'b1, 1'b0));
    send_word(mk_word(63, 31, 31, 1'b0, 1'b0));
    send_word(mk_word(0, 5, 30, 1'b1, 1'b0));
    send_word(mk_word(63, 2, 31, 1'b1, 1'b1));
    send_word(mk_word(0, 1, 2, 1'b1, 1'b0));
    send_word(mk_word(0, 3, 7, 1'b1, 1'b0));
    send_word(mk_word(0, 9, 0, 1'b1, 1'b0));
    send_word(mk_word(0, 2, 3, 1'b1, 1'b0));
    send_word(mk_word(4, 0, 0, 1'b0, 1'b1));
    send_word(mk_word(0, 0, 1, 1'b1, 1'b0));
    send_word(mk_word(0, 1, 2, 1'b1, 1'b0));
    send_word(mk_word(0, 2, 1, 1'b1, 1'b0));
    send_word(mk_word(0, 2, 3, 1'b1, 1'b0));
    send_word(mk_word(0, 4, 5, 1'b1, 1'b0));
    send_word(mk_word(6, 0, 0, 1'b0, 1'b1));
    send_word(mk_word(33, 21, 10, 1'b0, 1'b1));
    send_word(mk_word(32, 0, 0, 1'b0, 1'b1));
    wait_drain();
  endtask

  task automatic test_overflow();
    sender_smooth = 1'($urandom_range(0, 1));
    send_graph(GRAPH_DAG, tse_pkg::MAX_NODES, tse_pkg::MAX_EDGES + 4);
    send_graph(GRAPH_DAG, 3, 2);
    wait_drain();
  endtask

  task automatic test_receiver_hold();
    sender_smooth = 1'b1;
    hold_len = 500;
    hold_seq++;
    send_graph(GRAPH_DAG, 12, 10);
    send_graph(GRAPH_DAG, 8, 6);
    send_graph(GRAPH_CYCLIC, 5, 4);
    wait_drain();
  endtask

  task automatic test_random_graphs();
    int start, pick, kind, n, m;
    start = words_counted;
    while (words_counted - start < RANDOM_WORDS) begin
      pick = $urandom_range(0, 19);
      kind = (pick < 14) ? GRAPH_DAG : (pick < 17) ? GRAPH_CYCLIC : GRAPH_NOISE;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(11, tse_pkg::MAX_NODES)
                                      : $urandom_range(0, 10);
      if (n < 2) m = $urandom_range(0, 2);
      else m = $urandom_range(0, (2 * n > 24) ? 24 : 2 * n);
      if (kind == GRAPH_CYCLIC && m == 0) m = 1;
      sender_smooth = ($urandom_range(0, 3) == 0);
      send_graph(kind, n, m);
      if ($urandom_range(0, 9) == 0) wait_drain();
    end
    wait_drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_overflow();
    test_receiver_hold();
    test_random_graphs();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
